// ===== src/kts_pkg.sv =====
// Package: command and status codes and sequencer state type for the timeout slot table.
`timescale 1ns / 1ps
package kts_pkg;

	localparam logic [2:0] CMD_TICK      = 3'd0;
	localparam logic [2:0] CMD_SET       = 3'd1;
	localparam logic [2:0] CMD_CLEAR     = 3'd2;
	localparam logic [2:0] CMD_QRUN      = 3'd3;
	localparam logic [2:0] CMD_QEXP      = 3'd4;
	localparam logic [2:0] CMD_RESET_ALL = 3'd5;

	localparam logic [1:0] STAT_DONE    = 2'd0;
	localparam logic [1:0] STAT_PRESENT = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;

	localparam int TYPE_W  = 4;
	localparam int DELAY_W = 32;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_ACT  = 3'b100
	} seq_state_t;

endpackage

// ===== src/keyed_timeout_slot_table.sv =====
// Top level: keyed timeout slot table with a slot-serial scan sequencer.
// Each transaction scans the slots in turn in S_SCAN through the single slot read port
// and shared compare/decrement unit, then updates the slots and writes the result register
// in S_ACT, which waits while a held result has not been taken downstream.
// A new transaction is taken only in S_IDLE, after the last one has written its result; the
// result register lets the next transaction be taken while a result waits downstream.
// Reset: arst_n clears every slot key and expired flag (all slots free) and the sequencer.
`timescale 1ns / 1ps
module keyed_timeout_slot_table import kts_pkg::*; #(
	parameter int SLOT_COUNT = 8,
	parameter int KEY_BITS   = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // command[2:0], timeout_type[6:3], delay[38:7], zero[39]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // status[1:0], running[2], expired[3], zero[7:4]
);

	localparam int KW    = (KEY_BITS < TYPE_W) ? KEY_BITS : TYPE_W;
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	seq_state_t state_q;

	logic [KW-1:0]      slot_key_q [SLOT_COUNT];
	logic               slot_exp_q [SLOT_COUNT];
	logic [DELAY_W-1:0] slot_cnt_q [SLOT_COUNT];

	logic [2:0]         cmd_q;
	logic [KW-1:0]      key_q;
	logic [DELAY_W-1:0] delay_q;
	logic [IDX_W-1:0]   idx_q;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic               hit_exp_q;
	logic               free_q;
	logic [IDX_W-1:0]   free_idx_q;

	logic               out_valid_q;
	logic [7:0]         out_data_q;

	logic               in_acc;
	logic               wr_out;
	logic [KW-1:0]      cur_key;
	logic               cur_exp;
	logic [DELAY_W-1:0] cur_cnt;
	logic               cur_match;
	logic               cur_free;
	logic               cnt_low;
	logic               tick_upd;
	logic [1:0]         res_status;
	logic               res_running;
	logic               res_expired;
	logic               do_set;
	logic               do_free;
	logic [IDX_W-1:0]   free_slot_idx;
	logic               do_reset_all;

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign wr_out   = (state_q == S_ACT) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// shared slot read port and compare / decrement unit
	assign cur_key   = slot_key_q[idx_q];
	assign cur_exp   = slot_exp_q[idx_q];
	assign cur_cnt   = slot_cnt_q[idx_q];
	assign cur_match = (key_q != '0) && (cur_key == key_q);
	assign cur_free  = (cur_key == '0);
	assign cnt_low   = (cur_cnt <= DELAY_W'(1));
	assign tick_upd  = (state_q == S_SCAN) && (cmd_q == CMD_TICK) && !cur_free && !cur_exp;

	always_comb begin
		res_status    = STAT_DONE;
		res_running   = 1'b0;
		res_expired   = 1'b0;
		do_set        = 1'b0;
		do_free       = 1'b0;
		do_reset_all  = 1'b0;
		free_slot_idx = hit_idx_q;
		unique case (cmd_q)
			CMD_SET: begin
				res_running = hit_q;
				if (key_q != '0) begin
					if (hit_q) begin
						res_status = STAT_PRESENT;
					end else if (free_q) begin
						do_set = 1'b1;
					end else begin
						res_status = STAT_FULL;
					end
				end
			end
			CMD_CLEAR: begin
				res_running = hit_q;
				do_free     = hit_q;
			end
			CMD_QRUN: begin
				res_running = hit_q;
			end
			CMD_QEXP: begin
				res_running = hit_q;
				res_expired = hit_q && hit_exp_q;
				do_free     = hit_q && hit_exp_q;
			end
			CMD_RESET_ALL: begin
				do_reset_all = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_SCAN;
						idx_q   <= '0;
					end
				end
				S_SCAN: begin
					if (idx_q == LAST_IDX) begin
						state_q <= S_ACT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_ACT: begin
					if (wr_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q   <= s_tdata[2:0];
			key_q   <= s_tdata[3 +: KW];
			delay_q <= s_tdata[7 +: DELAY_W];
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
		end else if (state_q == S_SCAN) begin
			if (cur_match && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_q;
				hit_exp_q <= cur_exp;
			end
			if (cur_free && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_q;
			end
		end
		if (wr_out) begin
			out_data_q <= {4'b0000, res_expired, res_running, res_status};
		end
	end

	// slot keys and expired flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_key_q[i] <= '0;
				slot_exp_q[i] <= 1'b0;
			end
		end else if (tick_upd) begin
			if (cnt_low) begin
				slot_exp_q[idx_q] <= 1'b1;
			end
		end else if (wr_out) begin
			if (do_reset_all) begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					slot_key_q[i] <= '0;
					slot_exp_q[i] <= 1'b0;
				end
			end else if (do_set) begin
				slot_key_q[free_idx_q] <= key_q;
				slot_exp_q[free_idx_q] <= 1'b0;
			end else if (do_free) begin
				slot_key_q[free_slot_idx] <= '0;
				slot_exp_q[free_slot_idx] <= 1'b0;
			end
		end
	end

	// countdowns; only read while the slot holds a key
	always_ff @(posedge clk) begin
		if (tick_upd) begin
			slot_cnt_q[idx_q] <= cnt_low ? '0 : (cur_cnt - DELAY_W'(1));
		end else if (wr_out && do_set) begin
			slot_cnt_q[free_idx_q] <= delay_q;
		end
	end

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_SCAN) && (idx_q == '0))
		else $error("accepted transaction did not start a scan at slot 0");

	a_set_writes_key: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_out && do_set) |=> (slot_key_q[$past(free_idx_q)] == $past(key_q)))
		else $error("set did not store its key in the free slot");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] != 2'd3))
		else $error("undefined status code");

	a_expired_needs_running: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[3]) |-> m_tdata[2])
		else $error("expired reported for an absent type");

endmodule
